/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: field widths,
// command and register codes, alignment and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

	// Field widths of the request, response and configuration channels.
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 24;
	localparam int STAT_BLK_W = 5;
	localparam int CFG_IDX_W  = 1;

	// One descriptor holds a start offset and a rounded length.
	localparam int ENTRY_W = 2 * SIZE_W;

	// Allocation granule: every length is rounded up to a multiple of this many bytes.
	localparam int ALIGN_LOG2  = 3;
	localparam int ALIGN_BYTES = 1 << ALIGN_LOG2;

	// Request commands.
	localparam logic CMD_ALLOCATE = 1'b0;
	localparam logic CMD_RELEASE  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LENGTH = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_WALK,
		ST_TAIL,
		ST_UP_PRIME,
		ST_UP,
		ST_PUT,
		ST_REL,
		ST_DN,
		ST_DONE
	} ffba_state_t;

endpackage : ffba_pkg

`default_nettype wire

/* rtl/ffba_ifs.sv */
// ----------------------------------------------------------------------------
// ffba channel interfaces
// Valid/ready channels of the allocator: request, response and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffba_req_if import ffba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [SIZE_W-1:0] request_size;
	logic [ADDR_W-1:0] block_address;

	modport source (output valid, command, request_size, block_address, input ready);
	modport sink   (input valid, command, request_size, block_address, output ready);
endinterface : ffba_req_if

interface ffba_rsp_if import ffba_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  success;
	logic [ADDR_W-1:0]     granted_address;
	logic [SIZE_W-1:0]     used_bytes;
	logic [SIZE_W-1:0]     peak_used_bytes;
	logic [STAT_BLK_W-1:0] used_blocks;
	logic [STAT_BLK_W-1:0] peak_used_blocks;

	modport source (output valid, success, granted_address, used_bytes, peak_used_bytes,
		used_blocks, peak_used_blocks, input ready);
	modport sink   (input valid, success, granted_address, used_bytes, peak_used_bytes,
		used_blocks, peak_used_blocks, output ready);
endinterface : ffba_rsp_if

interface ffba_cfg_if import ffba_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ADDR_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface : ffba_cfg_if

`default_nettype wire

/* rtl/ffba_gap_unit.sv */
// ----------------------------------------------------------------------------
// ffba_gap_unit
// Shared gap check: does the space from lo up to hi hold the rounded size?
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_gap_unit import ffba_pkg::*; (
	input  wire logic [SIZE_W:0] hi,
	input  wire logic [SIZE_W:0] lo,
	input  wire logic [SIZE_W:0] need,
	output logic                 fit
);

	logic [SIZE_W+1:0] diff;

	// A negative difference means the lower bound already lies beyond hi.
	always_comb begin
		diff = {1'b0, hi} - {1'b0, lo};
		fit  = !diff[SIZE_W+1] && (diff[SIZE_W:0] >= need);
	end

endmodule : ffba_gap_unit

`default_nettype wire

/* rtl/first_fit_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit heap allocator over an address-sorted descriptor table.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+--------------------------------------------
//  cfg     | in  | valid / ready   | index, data (heap_base, heap_length)
//  req     | in  | valid / ready   | command, request_size, block_address
//  rsp     | out | valid / ready   | success, granted_address, used_bytes,
//          |     |                 | peak_used_bytes, used_blocks, peak_used_blocks
//
// An allocate walks the descriptors to the first gap that fits, then moves the
// later ones one place up; a release compares descriptors until one matches,
// then moves the later ones one place down. A refused request moves nothing.
// The descriptor memory is read one entry a cycle.
// Reset clears the counters and configuration; the table needs no clearing.
// A new request is taken while the previous response waits in its register;
// a stalled response holds the sequencer in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_core import ffba_pkg::*; #(
	parameter int MAX_BLOCKS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ffba_cfg_if.sink    cfg,
	ffba_req_if.sink    req,
	ffba_rsp_if.source  rsp
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [SIZE_W:0] RND_MASK = (SIZE_W + 1)'(ALIGN_BYTES - 1);

	ffba_state_t state_q, state_d;

	// Configuration and statistics.
	logic [ADDR_W-1:0] heap_base_q;
	logic [SIZE_W-1:0] heap_length_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     peak_blocks_q;
	logic [SIZE_W-1:0] bytes_q;
	logic [SIZE_W-1:0] peak_bytes_q;

	// Working registers of the current request.
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W:0]   rounded_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     pos_q;
	logic [SIZE_W-1:0] off_q;
	logic [SIZE_W:0]   prev_end_q;
	logic              success_q;
	logic [ADDR_W-1:0] granted_q;

	// Response register.
	logic                  rsp_valid_q;
	logic                  rsp_success_q;
	logic [ADDR_W-1:0]     rsp_granted_q;
	logic [SIZE_W-1:0]     rsp_bytes_q;
	logic [SIZE_W-1:0]     rsp_peak_bytes_q;
	logic [STAT_BLK_W-1:0] rsp_blocks_q;
	logic [STAT_BLK_W-1:0] rsp_peak_blocks_q;

	// Descriptor memory.
	logic [ENTRY_W-1:0] desc_mem [MAX_BLOCKS];
	logic [ENTRY_W-1:0] rd_q;
	logic [IW-1:0]      mem_ra;
	logic [IW-1:0]      mem_wa;
	logic [ENTRY_W-1:0] mem_wd;
	logic               mem_we;

	// Decoded conditions.
	logic              req_fire;
	logic              rsp_free;
	logic [SIZE_W:0]   round_sum;
	logic [SIZE_W-1:0] ent_start;
	logic [SIZE_W-1:0] ent_len;
	logic [SIZE_W:0]   ent_end;
	logic              ptr_zero;
	logic              ptr_last;
	logic              ptr_second_last;
	logic              table_full;
	logic              rel_match;
	logic              walk_fit;
	logic [SIZE_W:0]   gap_hi;
	logic [SIZE_W:0]   gap_lo;
	logic              gap_fit;
	logic [SIZE_W-1:0] bytes_inc;
	logic [CW-1:0]     count_inc;

	assign req_fire        = req.valid && req.ready;
	assign rsp_free        = !rsp_valid_q || rsp.ready;
	assign round_sum       = ({1'b0, req.request_size} + RND_MASK) & ~RND_MASK;
	assign ent_start       = rd_q[ENTRY_W-1:SIZE_W];
	assign ent_len         = rd_q[SIZE_W-1:0];
	assign ent_end         = {1'b0, ent_start} + {1'b0, ent_len};
	assign ptr_zero        = (ptr_q == '0);
	assign ptr_last        = ((ptr_q + CW'(1)) == count_q);
	assign ptr_second_last = ((ptr_q + CW'(2)) == count_q);
	assign table_full      = (count_q == CW'(MAX_BLOCKS));
	assign rel_match       = ((heap_base_q + {{(ADDR_W - SIZE_W){1'b0}}, ent_start}) == addr_q);
	assign walk_fit        = gap_fit && (!ptr_zero || (ent_start != '0));
	assign bytes_inc       = bytes_q + rounded_q[SIZE_W-1:0];
	assign count_inc       = count_q + CW'(1);

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// Operand selection for the shared gap check.
	always_comb begin
		gap_hi = {1'b0, heap_length_q};
		gap_lo = '0;
		case (state_q)
			ST_WALK: begin
				gap_hi = {1'b0, ent_start};
				gap_lo = ptr_zero ? '0 : prev_end_q;
			end
			ST_TAIL: begin
				gap_lo = prev_end_q;
			end
			default: begin
				gap_lo = '0;
			end
		endcase
	end

	ffba_gap_unit u_gap (
		.hi   (gap_hi),
		.lo   (gap_lo),
		.need (rounded_q),
		.fit  (gap_fit)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d = state_q;
		mem_ra  = IW'(ptr_q + CW'(1));
		mem_we  = 1'b0;
		mem_wa  = ptr_q[IW-1:0];
		mem_wd  = rd_q;
		case (state_q)
			ST_IDLE: begin
				mem_ra = '0;
				if (req.valid) begin
					state_d = (req.command == CMD_ALLOCATE) ? ST_ALLOC : ST_REL;
				end
			end
			ST_ALLOC: begin
				mem_ra = '0;
				if (table_full || rounded_q[SIZE_W]) begin
					state_d = ST_DONE;
				end else if (count_q == '0) begin
					state_d = gap_fit ? ST_PUT : ST_DONE;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_fit) begin
					state_d = ST_UP_PRIME;
				end else if (ptr_last) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = gap_fit ? ST_PUT : ST_DONE;
			end
			ST_UP_PRIME: begin
				mem_ra  = IW'(count_q - CW'(1));
				state_d = ST_UP;
			end
			ST_UP: begin
				// Move the entry read last cycle one place up, read the next lower one.
				mem_we = 1'b1;
				mem_wa = IW'(ptr_q + CW'(1));
				mem_ra = IW'(ptr_q - CW'(1));
				if (ptr_q == pos_q) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				mem_we  = 1'b1;
				mem_wa  = pos_q[IW-1:0];
				mem_wd  = {off_q, rounded_q[SIZE_W-1:0]};
				state_d = ST_DONE;
			end
			ST_REL: begin
				if (count_q == '0) begin
					state_d = ST_DONE;
				end else if (rel_match) begin
					state_d = ptr_last ? ST_DONE : ST_DN;
				end else if (ptr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DN: begin
				// Move the following entry one place down over the released one.
				mem_we = 1'b1;
				mem_ra = IW'(ptr_q + CW'(2));
				if (ptr_second_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Descriptor memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			desc_mem[mem_wa] <= mem_wd;
		end
		rd_q <= desc_mem[mem_ra];
	end

	// Working registers of the request in progress.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					addr_q    <= req.block_address;
					rounded_q <= round_sum;
					ptr_q     <= '0;
					success_q <= 1'b0;
					granted_q <= '0;
				end
			end
			ST_ALLOC: begin
				ptr_q <= '0;
				pos_q <= '0;
				off_q <= '0;
			end
			ST_WALK: begin
				if (walk_fit) begin
					pos_q <= ptr_q;
					off_q <= ptr_zero ? '0 : prev_end_q[SIZE_W-1:0];
				end else begin
					prev_end_q <= ent_end;
					ptr_q      <= ptr_q + CW'(1);
				end
			end
			ST_TAIL: begin
				pos_q <= count_q;
				off_q <= prev_end_q[SIZE_W-1:0];
			end
			ST_UP_PRIME: begin
				ptr_q <= count_q - CW'(1);
			end
			ST_UP: begin
				ptr_q <= ptr_q - CW'(1);
			end
			ST_PUT: begin
				success_q <= 1'b1;
				granted_q <= heap_base_q + {{(ADDR_W - SIZE_W){1'b0}}, off_q};
			end
			ST_REL: begin
				if (count_q != '0 && rel_match) begin
					success_q <= 1'b1;
				end else begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			ST_DN: begin
				ptr_q <= ptr_q + CW'(1);
			end
			default: begin
				success_q <= success_q;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q   <= '0;
			heap_length_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_HEAP_BASE) begin
				heap_base_q <= cfg.data;
			end else begin
				heap_length_q <= cfg.data[SIZE_W-1:0];
			end
		end
	end

	// Block count, bytes in use and their peaks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			peak_blocks_q <= '0;
			bytes_q       <= '0;
			peak_bytes_q  <= '0;
		end else begin
			case (state_q)
				ST_PUT: begin
					count_q <= count_inc;
					bytes_q <= bytes_inc;
					if (bytes_inc > peak_bytes_q) begin
						peak_bytes_q <= bytes_inc;
					end
					if (count_inc > peak_blocks_q) begin
						peak_blocks_q <= count_inc;
					end
				end
				ST_REL: begin
					if (count_q != '0 && rel_match) begin
						bytes_q <= bytes_q - ent_len;
						if (ptr_last) begin
							count_q <= count_q - CW'(1);
						end
					end
				end
				ST_DN: begin
					if (ptr_second_last) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload, captured as the request completes.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_success_q     <= success_q;
			rsp_granted_q     <= granted_q;
			rsp_bytes_q       <= bytes_q;
			rsp_peak_bytes_q  <= peak_bytes_q;
			rsp_blocks_q      <= STAT_BLK_W'(count_q);
			rsp_peak_blocks_q <= STAT_BLK_W'(peak_blocks_q);
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.success          = rsp_success_q;
	assign rsp.granted_address  = rsp_granted_q;
	assign rsp.used_bytes       = rsp_bytes_q;
	assign rsp.peak_used_bytes  = rsp_peak_bytes_q;
	assign rsp.used_blocks      = rsp_blocks_q;
	assign rsp.peak_used_blocks = rsp_peak_blocks_q;

endmodule : first_fit_block_allocator_core

`default_nettype wire

/* sim/tb_first_fit_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_core
// Self-checking bench for the first-fit allocator. A directed burst covers the
// size extremes, gap placement, address wrap, unknown releases and a full
// table. Random phases under several heap settings follow. Each accepted
// request is run through a local heap model, and every response is checked
// against the oldest outcome still awaited. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_first_fit_block_allocator_core;
	import ffba_pkg::*;

	localparam int BLOCK_SLOTS   = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam longint unsigned SIZE_LIMIT = (64'd1 << SIZE_W) - 1;

	typedef struct {
		logic              command;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] block_address;
		bit                pick_live;
	} heap_request_t;

	typedef struct packed {
		logic                  success;
		logic [ADDR_W-1:0]     granted_address;
		logic [SIZE_W-1:0]     used_bytes;
		logic [SIZE_W-1:0]     peak_used_bytes;
		logic [STAT_BLK_W-1:0] used_blocks;
		logic [STAT_BLK_W-1:0] peak_used_blocks;
	} heap_outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	ffba_req_if req_bus ();
	ffba_rsp_if rsp_bus ();
	ffba_cfg_if cfg_bus ();

	first_fit_block_allocator_core #(
		.MAX_BLOCKS(BLOCK_SLOTS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// Local copy of the heap: configuration, sorted descriptor table, counters.
	logic [ADDR_W-1:0]     heap_base_cfg   = '0;
	logic [SIZE_W-1:0]     heap_length_cfg = '0;
	logic [SIZE_W-1:0]     live_start [BLOCK_SLOTS];
	logic [SIZE_W-1:0]     live_len   [BLOCK_SLOTS];
	logic [STAT_BLK_W-1:0] live_count  = '0;
	logic [SIZE_W-1:0]     bytes_in_use = '0;
	logic [SIZE_W-1:0]     bytes_peak   = '0;
	logic [STAT_BLK_W-1:0] blocks_peak  = '0;

	heap_request_t request_backlog [$];
	heap_outcome_t pending_outcomes [$];
	heap_request_t offered;
	int            burst_left = 1;
	int            gap_left   = 0;
	int            error_count = 0;
	bit            receiver_hold = 1'b0;
	logic [15:0]   stall_mask = 16'hFFFF;
	logic [5:0]    pattern_step = '0;
	event          hold_receiver;

	always #5 clk = ~clk;

	// Apply one request to the local heap and return the response it must give.
	function automatic heap_outcome_t heap_outcome(heap_request_t r);
		heap_outcome_t     res;
		longint unsigned   rounded;
		longint unsigned   gap_end;
		longint unsigned   gap_limit;
		logic [SIZE_W-1:0] offset;
		logic [ADDR_W-1:0] absolute;
		bit                granted;
		int                slot;
		granted = 1'b0;
		offset  = '0;
		slot    = 0;
		if (r.command == CMD_ALLOCATE) begin
			rounded = ((64'(r.request_size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
			if (live_count < BLOCK_SLOTS && rounded <= SIZE_LIMIT) begin
				if (live_count == 0) begin
					granted = (heap_length_cfg >= rounded);
				end else if (live_start[0] != 0 && live_start[0] >= rounded) begin
					granted = 1'b1;
				end else begin
					// Walk the gaps behind each block; the last one ends at the heap end.
					for (int i = 0; i < live_count && !granted; i++) begin
						gap_end = 64'(live_start[i]) + 64'(live_len[i]);
						gap_limit = (i + 1 < live_count) ? 64'(live_start[i + 1])
							: 64'(heap_length_cfg);
						if (gap_limit >= gap_end && gap_limit - gap_end >= rounded) begin
							granted = 1'b1;
							slot    = i + 1;
							offset  = gap_end[SIZE_W-1:0];
						end
					end
				end
			end
			if (granted) begin
				for (int j = live_count; j > slot; j--) begin
					live_start[j] = live_start[j - 1];
					live_len[j]   = live_len[j - 1];
				end
				live_start[slot] = offset;
				live_len[slot]   = rounded[SIZE_W-1:0];
				live_count   = live_count + 1'b1;
				bytes_in_use = bytes_in_use + rounded[SIZE_W-1:0];
				if (bytes_in_use > bytes_peak)
					bytes_peak = bytes_in_use;
				if (live_count > blocks_peak)
					blocks_peak = live_count;
			end
		end else begin
			// A release removes the first block whose absolute start matches.
			for (int i = 0; i < live_count && !granted; i++) begin
				absolute = heap_base_cfg + live_start[i];
				if (absolute == r.block_address) begin
					granted = 1'b1;
					slot    = i;
				end
			end
			if (granted) begin
				bytes_in_use = bytes_in_use - live_len[slot];
				for (int j = slot; j + 1 < live_count; j++) begin
					live_start[j] = live_start[j + 1];
					live_len[j]   = live_len[j + 1];
				end
				live_count = live_count - 1'b1;
			end
		end
		res.success          = granted;
		res.granted_address  = (granted && r.command == CMD_ALLOCATE) ?
			heap_base_cfg + offset : '0;
		res.used_bytes       = bytes_in_use;
		res.peak_used_bytes  = bytes_peak;
		res.used_blocks      = live_count;
		res.peak_used_blocks = blocks_peak;
		return res;
	endfunction

	function automatic string describe(heap_outcome_t o);
		return $sformatf("ok=%0d addr=%h used=%h peak=%h blocks=%0d peak_blocks=%0d",
			o.success, o.granted_address, o.used_bytes, o.peak_used_bytes,
			o.used_blocks, o.peak_used_blocks);
	endfunction

	task automatic note_failure(string what);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	// Request driver: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		bit send_next;
		send_next = 1'b0;
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready)
				pending_outcomes.push_back(heap_outcome(offered));
			if (!req_bus.valid || req_bus.ready) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (request_backlog.size() != 0) begin
					offered = request_backlog.pop_front();
					// Releases of live blocks are resolved against the heap as it now stands.
					if (offered.pick_live && live_count != 0)
						offered.block_address = heap_base_cfg +
							live_start[$urandom_range(0, live_count - 1)];
					send_next = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
				req_bus.valid <= send_next;
				if (send_next) begin
					req_bus.command       <= offered.command;
					req_bus.request_size  <= offered.request_size;
					req_bus.block_address <= offered.block_address;
				end
			end
		end
	end

	// Response monitor and receiver stall pattern.
	always @(posedge clk) begin
		heap_outcome_t seen;
		heap_outcome_t want;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				seen = {rsp_bus.success, rsp_bus.granted_address, rsp_bus.used_bytes,
					rsp_bus.peak_used_bytes, rsp_bus.used_blocks, rsp_bus.peak_used_blocks};
				if (pending_outcomes.size() == 0) begin
					note_failure({"response with none awaited: ", describe(seen)});
				end else begin
					want = pending_outcomes.pop_front();
					if (seen !== want)
						note_failure({"mismatch: expected ", describe(want),
							" got ", describe(seen)});
				end
			end
			pattern_step <= pattern_step + 1'b1;
			if (pattern_step == 0) begin
				case ($urandom_range(0, 3))
					0: stall_mask <= 16'hFFFF;
					1: stall_mask <= 16'($urandom);
					2: stall_mask <= 16'($urandom | $urandom);
					default: stall_mask <= 16'hA5A5;
				endcase
			end
			rsp_bus.ready <= !receiver_hold && stall_mask[pattern_step[3:0]];
		end
	end

	// Long receiver hold-off, so that the block fills up and stalls its input.
	always begin
		@(hold_receiver);
		receiver_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold <= 1'b0;
	end

	task automatic write_heap_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			REG_HEAP_BASE:   heap_base_cfg   = value;
			REG_HEAP_LENGTH: heap_length_cfg = value[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	// Waits until the backlog is empty, no request is offered and every awaited response has arrived.
	// The check runs on the falling edge, once the driver's updates have settled.
	task automatic wait_until_idle();
		while (request_backlog.size() != 0 || req_bus.valid || pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_request(logic cmd, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
		heap_request_t r;
		r.command       = cmd;
		r.request_size  = size;
		r.block_address = addr;
		r.pick_live     = 1'b0;
		request_backlog.push_back(r);
	endtask

	// Mostly small sizes, with some full-range and some near the top of the field.
	task automatic queue_random(int count, int unsigned size_cap);
		heap_request_t r;
		int unsigned   roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 9);
			if (roll == 0)
				r.request_size = 24'($urandom);
			else if (roll == 1)
				r.request_size = 24'(SIZE_LIMIT - $urandom_range(0, 15));
			else
				r.request_size = 24'($urandom_range(0, size_cap));
			r.block_address = $urandom;
			r.pick_live     = 1'b0;
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				r.command = CMD_ALLOCATE;
			end else begin
				r.command   = CMD_RELEASE;
				r.pick_live = (roll < 90);
			end
			request_backlog.push_back(r);
		end
	endtask

	// Stimulus: reset, directed requests, then random phases under new settings.
	initial begin
		arst_n                = 1'b0;
		req_bus.valid         = 1'b0;
		req_bus.command       = CMD_ALLOCATE;
		req_bus.request_size  = '0;
		req_bus.block_address = '0;
		rsp_bus.ready         = 1'b0;
		cfg_bus.valid         = 1'b0;
		cfg_bus.index         = REG_HEAP_BASE;
		cfg_bus.data          = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Heap near the top of the address space, so that late blocks wrap.
		write_heap_register(REG_HEAP_BASE, 32'hFFFF_FF00);
		write_heap_register(REG_HEAP_LENGTH, {8'hA5, 24'h000200});
		queue_request(CMD_ALLOCATE, 24'hFFFFFF, $urandom);
		queue_request(CMD_ALLOCATE, 24'hFFFFF8, $urandom);
		queue_request(CMD_ALLOCATE, 24'd1, $urandom);
		queue_request(CMD_ALLOCATE, 24'd0, $urandom);
		queue_request(CMD_ALLOCATE, 24'd100, $urandom);
		queue_request(CMD_ALLOCATE, 24'd256, $urandom);
		queue_request(CMD_ALLOCATE, 24'd200, $urandom);
		queue_request(CMD_ALLOCATE, 24'd144, $urandom);
		queue_request(CMD_RELEASE, 24'($urandom), 32'hFFFF_FF08);
		queue_request(CMD_RELEASE, 24'($urandom), 32'hFFFF_FF00);
		queue_request(CMD_ALLOCATE, 24'd8, $urandom);
		queue_request(CMD_ALLOCATE, 24'd1, $urandom);
		queue_request(CMD_RELEASE, 24'($urandom), 32'h1234_5678);
		queue_request(CMD_RELEASE, 24'($urandom), 32'h0000_0070);
		// Zero-size blocks fill the table, then one more is refused.
		repeat (13) queue_request(CMD_ALLOCATE, 24'd0, $urandom);
		queue_request(CMD_ALLOCATE, 24'd8, $urandom);
		wait_until_idle();

		// Shrunken heap with the table still full of blocks.
		write_heap_register(REG_HEAP_LENGTH, {8'h00, 24'h000040});
		queue_random(150, 64);
		wait_until_idle();

		write_heap_register(REG_HEAP_BASE, 32'hFFFF_FFFF);
		write_heap_register(REG_HEAP_LENGTH, {8'hFF, 24'hFFFFFF});
		queue_random(200, 24'hFFFFFF);
		wait_until_idle();

		write_heap_register(REG_HEAP_BASE, 32'h0000_0000);
		write_heap_register(REG_HEAP_LENGTH, 32'h0000_0000);
		queue_random(150, 32);
		wait_until_idle();

		// Receiver holds off while the sender keeps offering requests.
		write_heap_register(REG_HEAP_BASE, $urandom);
		write_heap_register(REG_HEAP_LENGTH, {8'($urandom), 24'h000400});
		queue_random(250, 96);
		-> hold_receiver;
		wait_until_idle();

		write_heap_register(REG_HEAP_BASE, $urandom);
		write_heap_register(REG_HEAP_LENGTH, {8'($urandom), 24'($urandom_range(0, 4095))});
		queue_random(200, 256);
		wait_until_idle();

		write_heap_register(REG_HEAP_BASE, $urandom);
		write_heap_register(REG_HEAP_LENGTH, $urandom);
		queue_random(200, 4096);
		wait_until_idle();

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog for a block that stops answering.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule : tb_first_fit_block_allocator_core

`default_nettype wire

/* files.f */
rtl/ffba_pkg.sv
rtl/ffba_ifs.sv
rtl/ffba_gap_unit.sv
rtl/first_fit_block_allocator_core.sv
sim/tb_first_fit_block_allocator_core.sv
